// ===== hw/rtl/urc_pkg.sv =====
// Shared types, codes and sizes of the ultrasonic ranging controller.
package urc_pkg;

	localparam int COUNTER_WIDTH = 32;
	localparam int STEP_W        = $clog2(COUNTER_WIDTH);
	localparam int CM_DIVISOR    = 58;
	localparam int TPU_W         = 8;
	localparam int CM_DIV_W      = 14;
	localparam int TICKS_W       = 24;
	localparam int PULSES_W      = 8;
	localparam int US_W          = 32;
	localparam int CM_W          = 27;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_PULSE = 2'd2;
	localparam logic [1:0] KIND_ECHO  = 2'd3;

	localparam logic [1:0] REG_TRIGGER_MODE  = 2'd0;
	localparam logic [1:0] REG_TRIGGER_TICKS = 2'd1;
	localparam logic [1:0] REG_TICKS_PER_US  = 2'd2;

	localparam logic [TICKS_W-1:0]  TRIGGER_TICKS_RST = 24'd360000;
	localparam logic [TPU_W-1:0]    TICKS_PER_US_RST  = 8'd72;
	localparam logic [PULSES_W-1:0] PULSE_LIMIT_RST   = 8'd9;

	typedef struct packed {
		logic [1:0]          kind;
		logic                channel;
		logic [PULSES_W-1:0] pulse_count;
		logic                echo_level;
	} req_t;

	typedef struct packed {
		logic            status;
		logic            trigger_a;
		logic            trigger_b;
		logic            distance_valid;
		logic [US_W-1:0] echo_us;
		logic [CM_W-1:0] range_cm;
		logic            result_channel;
	} rsp_t;

endpackage

// ===== hw/rtl/ultrasonic_ranging_controller.sv =====
// Two-channel ultrasonic ranging controller with an iterative echo-time divider.
//
// Every accepted request returns exactly one response. Ticks, start requests,
// pulse-finished events and rising echo edges are handled in the cycle they
// transfer and their response is registered the same edge, so they run one per
// cycle while the response is not stalled. A falling echo edge starts the shared
// restoring divider: it takes the tick counter and, one quotient bit per cycle,
// forms both the echo time in microseconds (ticks / ticks_per_us) and the
// distance in cm (ticks / (58 * ticks_per_us), which equals microseconds / 58).
// The divider runs in ST_DIV, then ST_FIN loads the response once the output
// register is free; req_stall stays high until then (longer while an earlier
// response is still stalled). A ticks_per_us of zero divides by one. The
// response sits in an output register, so a new request transfers while the
// previous response is still waiting, as long as that response is not stalled.
// Configuration writes are always taken (cfg_ready is tied high); write them
// only while the block is idle. Index 3 is ignored.
module ultrasonic_ranging_controller (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  urc_pkg::req_t               req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output urc_pkg::rsp_t               rsp,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [urc_pkg::TICKS_W-1:0] cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;

	// configuration
	logic                           mode_q;
	logic [urc_pkg::TICKS_W-1:0]    trig_ticks_q;
	logic [urc_pkg::TPU_W-1:0]      tpu_q;

	// channel state
	logic [urc_pkg::COUNTER_WIDTH-1:0] tick_cnt_q;
	logic                              busy_a_q, busy_b_q;
	logic [urc_pkg::PULSES_W-1:0]      done_a_q, done_b_q;
	logic [urc_pkg::PULSES_W-1:0]      limit_a_q, limit_b_q;
	logic [urc_pkg::TICKS_W-1:0]       left_a_q, left_b_q;

	// divider
	logic [urc_pkg::COUNTER_WIDTH-1:0] dvd_q;
	logic [urc_pkg::COUNTER_WIDTH-1:0] cmq_q;
	logic [urc_pkg::TPU_W-1:0]         rem_us_q;
	logic [urc_pkg::CM_DIV_W-1:0]      rem_cm_q;
	logic [urc_pkg::TPU_W-1:0]         div_us_q;
	logic [urc_pkg::CM_DIV_W-1:0]      div_cm_q;
	logic [urc_pkg::STEP_W-1:0]        step_q;
	logic                              ch_q;

	logic          rsp_valid_q;
	urc_pkg::rsp_t rsp_q;

	logic xfer_in, slot_free, rsp_load;
	logic [urc_pkg::TPU_W-1:0] divisor;

	// next channel state for a request in the current cycle
	logic                              nx_busy_a, nx_busy_b;
	logic [urc_pkg::PULSES_W-1:0]      nx_done_a, nx_done_b;
	logic [urc_pkg::PULSES_W-1:0]      nx_limit_a, nx_limit_b;
	logic [urc_pkg::TICKS_W-1:0]       nx_left_a, nx_left_b;
	logic [urc_pkg::COUNTER_WIDTH-1:0] nx_tick;
	logic                              nx_status;
	logic                              start_div;

	// one divider step
	logic [urc_pkg::TPU_W:0]    trial_us;
	logic [urc_pkg::CM_DIV_W:0] trial_cm;
	logic                       qbit_us, qbit_cm;
	logic                       dvd_msb;

	assign cfg_ready = 1'b1;
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE) || !slot_free;
	assign xfer_in   = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign divisor   = (tpu_q == '0) ? urc_pkg::TPU_W'(1) : tpu_q;
	// a new response enters the output register this edge
	assign rsp_load  = ((state_q == ST_IDLE) && xfer_in && !start_div)
		|| ((state_q == ST_FIN) && slot_free);

	always_comb begin
		nx_busy_a  = busy_a_q;
		nx_busy_b  = busy_b_q;
		nx_done_a  = done_a_q;
		nx_done_b  = done_b_q;
		nx_limit_a = limit_a_q;
		nx_limit_b = limit_b_q;
		nx_left_a  = left_a_q;
		nx_left_b  = left_b_q;
		nx_tick    = tick_cnt_q;
		nx_status  = 1'b0;
		start_div  = 1'b0;
		case (req.kind)
			urc_pkg::KIND_TICK: begin
				nx_tick = tick_cnt_q + urc_pkg::COUNTER_WIDTH'(1);
				if (!mode_q) begin
					// fixed mode: count each active trigger down, end it at one or zero
					if (busy_a_q) begin
						if (left_a_q <= urc_pkg::TICKS_W'(1)) begin
							nx_left_a = '0;
							nx_busy_a = 1'b0;
						end else begin
							nx_left_a = left_a_q - urc_pkg::TICKS_W'(1);
						end
					end
					if (busy_b_q) begin
						if (left_b_q <= urc_pkg::TICKS_W'(1)) begin
							nx_left_b = '0;
							nx_busy_b = 1'b0;
						end else begin
							nx_left_b = left_b_q - urc_pkg::TICKS_W'(1);
						end
					end
				end
			end
			urc_pkg::KIND_START: begin
				if (busy_a_q || busy_b_q) begin
					nx_status = 1'b1;
				end else if (!req.channel) begin
					nx_busy_a = 1'b1;
					if (mode_q) begin
						nx_done_a  = '0;
						nx_limit_a = req.pulse_count;
					end else begin
						nx_left_a = trig_ticks_q;
					end
				end else begin
					nx_busy_b = 1'b1;
					if (mode_q) begin
						nx_done_b  = '0;
						nx_limit_b = req.pulse_count;
					end else begin
						nx_left_b = trig_ticks_q;
					end
				end
			end
			urc_pkg::KIND_PULSE: begin
				// burst mode: count finished pulses, stop at the limit (zero stops at the first pulse)
				if (mode_q) begin
					if (!req.channel && busy_a_q) begin
						nx_done_a = done_a_q + urc_pkg::PULSES_W'(1);
						if (nx_done_a >= limit_a_q) begin
							nx_done_a = '0;
							nx_busy_a = 1'b0;
						end
					end
					if (req.channel && busy_b_q) begin
						nx_done_b = done_b_q + urc_pkg::PULSES_W'(1);
						if (nx_done_b >= limit_b_q) begin
							nx_done_b = '0;
							nx_busy_b = 1'b0;
						end
					end
				end
			end
			urc_pkg::KIND_ECHO: begin
				if (req.echo_level) begin
					nx_tick = '0;
				end else begin
					start_div = 1'b1;
				end
			end
			default: begin
				nx_tick = tick_cnt_q;
			end
		endcase
	end

	// shared restoring step: both lanes take the same dividend bit
	always_comb begin
		dvd_msb  = dvd_q[urc_pkg::COUNTER_WIDTH-1];
		trial_us = {rem_us_q, dvd_msb};
		trial_cm = {rem_cm_q, dvd_msb};
		qbit_us  = trial_us >= {1'b0, div_us_q};
		qbit_cm  = trial_cm >= {1'b0, div_cm_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mode_q       <= 1'b1;
			trig_ticks_q <= urc_pkg::TRIGGER_TICKS_RST;
			tpu_q        <= urc_pkg::TICKS_PER_US_RST;
			tick_cnt_q   <= '0;
			busy_a_q     <= 1'b0;
			busy_b_q     <= 1'b0;
			done_a_q     <= '0;
			done_b_q     <= '0;
			limit_a_q    <= urc_pkg::PULSE_LIMIT_RST;
			limit_b_q    <= urc_pkg::PULSE_LIMIT_RST;
			left_a_q     <= '0;
			left_b_q     <= '0;
			dvd_q        <= '0;
			cmq_q        <= '0;
			rem_us_q     <= '0;
			rem_cm_q     <= '0;
			div_us_q     <= '0;
			div_cm_q     <= '0;
			ch_q         <= 1'b0;
			step_q       <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					urc_pkg::REG_TRIGGER_MODE:  mode_q       <= cfg_data[0];
					urc_pkg::REG_TRIGGER_TICKS: trig_ticks_q <= cfg_data;
					urc_pkg::REG_TICKS_PER_US:  tpu_q        <= cfg_data[urc_pkg::TPU_W-1:0];
					default: ;
				endcase
			end

			// hold the response while stalled, drop it once it transfers, take a new one
			rsp_valid_q <= rsp_load || (rsp_valid_q && rsp_stall);

			case (state_q)
				ST_IDLE: begin
					if (xfer_in) begin
						tick_cnt_q <= nx_tick;
						busy_a_q   <= nx_busy_a;
						busy_b_q   <= nx_busy_b;
						done_a_q   <= nx_done_a;
						done_b_q   <= nx_done_b;
						limit_a_q  <= nx_limit_a;
						limit_b_q  <= nx_limit_b;
						left_a_q   <= nx_left_a;
						left_b_q   <= nx_left_b;
						if (start_div) begin
							dvd_q    <= tick_cnt_q;
							cmq_q    <= '0;
							rem_us_q <= '0;
							rem_cm_q <= '0;
							div_us_q <= divisor;
							div_cm_q <= urc_pkg::CM_DIV_W'(divisor)
								* urc_pkg::CM_DIV_W'(urc_pkg::CM_DIVISOR);
							ch_q     <= req.channel;
							step_q   <= '0;
							state_q  <= ST_DIV;
						end else begin
							rsp_q.status         <= nx_status;
							rsp_q.trigger_a      <= nx_busy_a;
							rsp_q.trigger_b      <= nx_busy_b;
							rsp_q.distance_valid <= 1'b0;
							rsp_q.echo_us        <= '0;
							rsp_q.range_cm       <= '0;
							rsp_q.result_channel <= 1'b0;
						end
					end
				end
				ST_DIV: begin
					// advance one quotient bit per lane
					rem_us_q <= qbit_us ? urc_pkg::TPU_W'(trial_us - {1'b0, div_us_q})
					                    : urc_pkg::TPU_W'(trial_us);
					rem_cm_q <= qbit_cm ? urc_pkg::CM_DIV_W'(trial_cm - {1'b0, div_cm_q})
					                    : urc_pkg::CM_DIV_W'(trial_cm);
					dvd_q    <= {dvd_q[urc_pkg::COUNTER_WIDTH-2:0], qbit_us};
					cmq_q    <= {cmq_q[urc_pkg::COUNTER_WIDTH-2:0], qbit_cm};
					step_q   <= step_q + urc_pkg::STEP_W'(1);
					if (step_q == urc_pkg::STEP_W'(urc_pkg::COUNTER_WIDTH - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold the quotients until the output register is free
					if (slot_free) begin
						rsp_q.status         <= 1'b0;
						rsp_q.trigger_a      <= busy_a_q;
						rsp_q.trigger_b      <= busy_b_q;
						rsp_q.distance_valid <= 1'b1;
						rsp_q.echo_us        <= urc_pkg::US_W'(dvd_q);
						rsp_q.range_cm       <= urc_pkg::CM_W'(cmq_q);
						rsp_q.result_channel <= ch_q;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
